// File: rtl/gbid_pkg.sv
package gbid_pkg;

    localparam logic [7:0] CB_PREFIX = 8'hCB;

    // operand selectors
    localparam logic [4:0] SEL_NONE  = 5'd0;
    localparam logic [4:0] SEL_A     = 5'd7;
    localparam logic [4:0] SEL_IMM8  = 5'd8;
    localparam logic [4:0] SEL_IMM16 = 5'd9;
    localparam logic [4:0] SEL_BCM   = 5'd10;
    localparam logic [4:0] SEL_DEM   = 5'd11;
    localparam logic [4:0] SEL_HLM   = 5'd12;
    localparam logic [4:0] SEL_HLI   = 5'd13;
    localparam logic [4:0] SEL_HLD   = 5'd14;
    localparam logic [4:0] SEL_ABS   = 5'd15;
    localparam logic [4:0] SEL_HIGHN = 5'd16;
    localparam logic [4:0] SEL_HIGHC = 5'd17;
    localparam logic [4:0] SEL_BC    = 5'd18;
    localparam logic [4:0] SEL_HL    = 5'd20;
    localparam logic [4:0] SEL_SP    = 5'd21;
    localparam logic [4:0] SEL_AF    = 5'd22;

    // operation classes
    localparam logic [6:0] OP_ILLEGAL  = 7'd0;
    localparam logic [6:0] OP_NOP      = 7'd1;
    localparam logic [6:0] OP_STOP     = 7'd2;
    localparam logic [6:0] OP_JRNZ     = 7'd3;
    localparam logic [6:0] OP_JRNC     = 7'd4;
    localparam logic [6:0] OP_LD16     = 7'd5;
    localparam logic [6:0] OP_LD8      = 7'd6;
    localparam logic [6:0] OP_INC16    = 7'd7;
    localparam logic [6:0] OP_INC8     = 7'd8;
    localparam logic [6:0] OP_DEC8     = 7'd9;
    localparam logic [6:0] OP_RLCA     = 7'd10;
    localparam logic [6:0] OP_RLA      = 7'd11;
    localparam logic [6:0] OP_DAA      = 7'd12;
    localparam logic [6:0] OP_SCF      = 7'd13;
    localparam logic [6:0] OP_JR       = 7'd14;
    localparam logic [6:0] OP_JRZ      = 7'd15;
    localparam logic [6:0] OP_JRC      = 7'd16;
    localparam logic [6:0] OP_ADD16    = 7'd17;
    localparam logic [6:0] OP_DEC16    = 7'd18;
    localparam logic [6:0] OP_RRCA     = 7'd19;
    localparam logic [6:0] OP_RRA      = 7'd20;
    localparam logic [6:0] OP_CPL      = 7'd21;
    localparam logic [6:0] OP_CCF      = 7'd22;
    localparam logic [6:0] OP_HALT     = 7'd23;
    localparam logic [6:0] OP_ADD8     = 7'd24;
    localparam logic [6:0] OP_RETNZ    = 7'd32;
    localparam logic [6:0] OP_RETNC    = 7'd33;
    localparam logic [6:0] OP_POP16    = 7'd34;
    localparam logic [6:0] OP_JPNZ     = 7'd35;
    localparam logic [6:0] OP_JPNC     = 7'd36;
    localparam logic [6:0] OP_JP       = 7'd37;
    localparam logic [6:0] OP_DI       = 7'd38;
    localparam logic [6:0] OP_CALLNZ   = 7'd39;
    localparam logic [6:0] OP_CALLNC   = 7'd40;
    localparam logic [6:0] OP_PUSH16   = 7'd41;
    localparam logic [6:0] OP_RST      = 7'd42;
    localparam logic [6:0] OP_RETZ     = 7'd43;
    localparam logic [6:0] OP_RETC     = 7'd44;
    localparam logic [6:0] OP_ADD8TO16 = 7'd45;
    localparam logic [6:0] OP_LDSPADD8 = 7'd46;
    localparam logic [6:0] OP_RET      = 7'd47;
    localparam logic [6:0] OP_RETI     = 7'd48;
    localparam logic [6:0] OP_JPZ      = 7'd49;
    localparam logic [6:0] OP_JPC      = 7'd50;
    localparam logic [6:0] OP_EI       = 7'd51;
    localparam logic [6:0] OP_CALLZ    = 7'd52;
    localparam logic [6:0] OP_CALLC    = 7'd53;
    localparam logic [6:0] OP_CALL     = 7'd54;
    localparam logic [6:0] OP_RLC      = 7'd55;
    localparam logic [6:0] OP_SRL_M1   = 7'd62; // BIT/RES/SET base: 62 + x

    typedef struct packed {
        logic [6:0] op_class;
        logic [1:0] instr_length;
        logic [4:0] base_cycles;
        logic [4:0] dst_operand;
        logic [4:0] src_operand;
        logic [5:0] bit_or_vector;
        logic       illegal;
    } dec_t;

    function automatic logic [4:0] reg_sel(input logic [2:0] r);
        logic [4:0] s;
        if (r == 3'd6)
            s = SEL_HLM;
        else if (r == 3'd7)
            s = SEL_A;
        else
            s = {2'b00, r} + 5'd1;
        return s;
    endfunction

endpackage

// File: rtl/gameboy_instruction_decoder.sv
// Channel | Dir | tdata fields (low bit first)
// s_axis  | in  | opcode_byte[7:0], prefix_operand_byte[15:8]
// m_axis  | out | op_class[6:0], instr_length[8:7], base_cycles[13:9],
//         |     | dst_operand[18:14], src_operand[23:19], bit_or_vector[29:24],
//         |     | illegal[30], zero fill to 40 bits
// One beat in, one beat out: the beat lands in the input register, is decoded,
// and is captured by the result register when the result stage can advance.
// One beat per cycle sustained: s_axis_tready drops only while both registers
// hold beats and m_axis_tready is low.
// Reset clears both valid flags; payload registers are not reset.
module gameboy_instruction_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // opcode_byte, prefix_operand_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // op_class, instr_length, base_cycles,
                                       // dst_operand, src_operand, bit_or_vector,
                                       // illegal, zero fill
);
    import gbid_pkg::*;

    logic        in_vld_reg;
    logic [15:0] in_dat_reg;
    logic        out_vld_reg;
    dec_t        out_reg;
    dec_t        dec;
    logic        adv;

    // advance the input stage when the result stage is empty or draining
    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = !in_vld_reg || adv;

    gbid_decode u_dec (
        .opcode_byte         (in_dat_reg[7:0]),
        .prefix_operand_byte (in_dat_reg[15:8]),
        .dec                 (dec)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_vld_reg <= s_axis_tvalid;
            if (adv)
                out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_dat_reg <= s_axis_tdata;
        if (adv && in_vld_reg)
            out_reg <= dec;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {9'd0, out_reg.illegal, out_reg.bit_or_vector,
                            out_reg.src_operand, out_reg.dst_operand,
                            out_reg.base_cycles, out_reg.instr_length,
                            out_reg.op_class};

    ap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");
    ap_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && adv |=> out_vld_reg)
        else $error("decoded beat lost");
    ap_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_vld_reg |-> s_axis_tready)
        else $error("input stalled with empty result stage");

endmodule

// File: rtl/gbid_decode.sv
module gbid_decode (
    input  logic [7:0]     opcode_byte,
    input  logic [7:0]     prefix_operand_byte,
    output gbid_pkg::dec_t dec
);
    import gbid_pkg::*;

    dec_t d;
    logic [1:0] x;
    logic [2:0] y;
    logic [2:0] z;
    logic [1:0] p;
    logic       q;
    logic [1:0] cx;
    logic [2:0] cy;
    logic [2:0] cz;

    function automatic dec_t mk(input logic [6:0] c, input logic [1:0] l,
                                input logic [4:0] cyc, input logic [4:0] ds,
                                input logic [4:0] sr);
        dec_t r;
        r.op_class      = c;
        r.instr_length  = l;
        r.base_cycles   = cyc;
        r.dst_operand   = ds;
        r.src_operand   = sr;
        r.bit_or_vector = 6'd0;
        r.illegal       = 1'b0;
        return r;
    endfunction

    assign x  = opcode_byte[7:6];
    assign y  = opcode_byte[5:3];
    assign z  = opcode_byte[2:0];
    assign p  = y[2:1];
    assign q  = y[0];
    assign cx = prefix_operand_byte[7:6];
    assign cy = prefix_operand_byte[5:3];
    assign cz = prefix_operand_byte[2:0];

    always_comb
    begin
        d = mk(OP_ILLEGAL, 2'd0, 5'd0, SEL_NONE, SEL_NONE);
        d.illegal = 1'b1;
        if (opcode_byte == CB_PREFIX)
        begin
            d = mk(OP_RLC, 2'd2, (cz == 3'd6) ? 5'd16 : 5'd8, reg_sel(cz), SEL_NONE);
            if (cx == 2'd0)
                d.op_class = OP_RLC + {4'd0, cy};
            else
            begin
                d.op_class      = OP_SRL_M1 + {5'd0, cx};
                d.bit_or_vector = {3'd0, cy};
                if (cx == 2'd1 && cz == 3'd6)
                    d.base_cycles = 5'd12;
            end
        end
        else if (x == 2'd1)
        begin
            if (z == 3'd6 && y == 3'd6)
                d = mk(OP_HALT, 2'd1, 5'd4, SEL_NONE, SEL_NONE);
            else
                d = mk(OP_LD8, 2'd1, (y == 3'd6 || z == 3'd6) ? 5'd8 : 5'd4,
                       reg_sel(y), reg_sel(z));
        end
        else if (x == 2'd2)
            d = mk(OP_ADD8 + {4'd0, y}, 2'd1, (z == 3'd6) ? 5'd8 : 5'd4, SEL_A, reg_sel(z));
        else if (x == 2'd0)
        begin
            case (z)
                3'd0:
                    case (y)
                        3'd0: d = mk(OP_NOP, 2'd1, 5'd4, SEL_NONE, SEL_NONE);
                        3'd1: d = mk(OP_LD16, 2'd3, 5'd20, SEL_ABS, SEL_SP);
                        3'd2: d = mk(OP_STOP, 2'd1, 5'd4, SEL_NONE, SEL_NONE);
                        3'd3: d = mk(OP_JR, 2'd2, 5'd12, SEL_IMM8, SEL_NONE);
                        3'd4: d = mk(OP_JRNZ, 2'd2, 5'd8, SEL_IMM8, SEL_NONE);
                        3'd5: d = mk(OP_JRZ, 2'd2, 5'd8, SEL_IMM8, SEL_NONE);
                        3'd6: d = mk(OP_JRNC, 2'd2, 5'd8, SEL_IMM8, SEL_NONE);
                        default: d = mk(OP_JRC, 2'd2, 5'd8, SEL_IMM8, SEL_NONE);
                    endcase
                3'd1:
                    if (!q)
                        d = mk(OP_LD16, 2'd3, 5'd12, SEL_BC + {3'd0, p}, SEL_IMM16);
                    else
                        d = mk(OP_ADD16, 2'd1, 5'd8, SEL_HL, SEL_BC + {3'd0, p});
                3'd2:
                begin
                    logic [4:0] m;
                    case (p)
                        2'd0: m = SEL_BCM;
                        2'd1: m = SEL_DEM;
                        2'd2: m = SEL_HLI;
                        default: m = SEL_HLD;
                    endcase
                    if (!q)
                        d = mk(OP_LD8, 2'd1, 5'd8, m, SEL_A);
                    else
                        d = mk(OP_LD8, 2'd1, 5'd8, SEL_A, m);
                end
                3'd3:
                    d = mk(q ? OP_DEC16 : OP_INC16, 2'd1, 5'd8, SEL_BC + {3'd0, p}, SEL_NONE);
                3'd4, 3'd5:
                    d = mk((z == 3'd4) ? OP_INC8 : OP_DEC8, 2'd1,
                           (y == 3'd6) ? 5'd12 : 5'd4, reg_sel(y), SEL_NONE);
                3'd6:
                    d = mk(OP_LD8, 2'd2, (y == 3'd6) ? 5'd12 : 5'd8, reg_sel(y), SEL_IMM8);
                default:
                begin
                    logic [6:0] c;
                    case (y)
                        3'd0: c = OP_RLCA;
                        3'd1: c = OP_RRCA;
                        3'd2: c = OP_RLA;
                        3'd3: c = OP_RRA;
                        3'd4: c = OP_DAA;
                        3'd5: c = OP_CPL;
                        3'd6: c = OP_SCF;
                        default: c = OP_CCF;
                    endcase
                    d = mk(c, 2'd1, 5'd4, y[2] & y[1] ? SEL_NONE : SEL_A, SEL_NONE);
                end
            endcase
        end
        else
        begin
            case (z)
                3'd0:
                    case (y)
                        3'd0: d = mk(OP_RETNZ, 2'd1, 5'd8, SEL_NONE, SEL_NONE);
                        3'd1: d = mk(OP_RETZ, 2'd1, 5'd8, SEL_NONE, SEL_NONE);
                        3'd2: d = mk(OP_RETNC, 2'd1, 5'd8, SEL_NONE, SEL_NONE);
                        3'd3: d = mk(OP_RETC, 2'd1, 5'd8, SEL_NONE, SEL_NONE);
                        3'd4: d = mk(OP_LD8, 2'd2, 5'd12, SEL_HIGHN, SEL_A);
                        3'd5: d = mk(OP_ADD8TO16, 2'd2, 5'd16, SEL_SP, SEL_IMM8);
                        3'd6: d = mk(OP_LD8, 2'd2, 5'd12, SEL_A, SEL_HIGHN);
                        default: d = mk(OP_LDSPADD8, 2'd2, 5'd12, SEL_HL, SEL_IMM8);
                    endcase
                3'd1:
                    if (!q)
                        d = mk(OP_POP16, 2'd1, 5'd12,
                               (p == 2'd3) ? SEL_AF : SEL_BC + {3'd0, p}, SEL_NONE);
                    else
                        case (p)
                            2'd0: d = mk(OP_RET, 2'd1, 5'd16, SEL_NONE, SEL_NONE);
                            2'd1: d = mk(OP_RETI, 2'd1, 5'd16, SEL_NONE, SEL_NONE);
                            2'd2: d = mk(OP_JP, 2'd1, 5'd4, SEL_HL, SEL_NONE);
                            default: d = mk(OP_LD16, 2'd1, 5'd8, SEL_SP, SEL_HL);
                        endcase
                3'd2:
                    case (y)
                        3'd0: d = mk(OP_JPNZ, 2'd3, 5'd12, SEL_IMM16, SEL_NONE);
                        3'd1: d = mk(OP_JPZ, 2'd3, 5'd12, SEL_IMM16, SEL_NONE);
                        3'd2: d = mk(OP_JPNC, 2'd3, 5'd12, SEL_IMM16, SEL_NONE);
                        3'd3: d = mk(OP_JPC, 2'd3, 5'd12, SEL_IMM16, SEL_NONE);
                        3'd4: d = mk(OP_LD8, 2'd1, 5'd8, SEL_HIGHC, SEL_A);
                        3'd5: d = mk(OP_LD8, 2'd3, 5'd16, SEL_ABS, SEL_A);
                        3'd6: d = mk(OP_LD8, 2'd1, 5'd8, SEL_A, SEL_HIGHC);
                        default: d = mk(OP_LD8, 2'd3, 5'd16, SEL_A, SEL_ABS);
                    endcase
                3'd3:
                    case (y)
                        3'd0: d = mk(OP_JP, 2'd3, 5'd16, SEL_IMM16, SEL_NONE);
                        3'd6: d = mk(OP_DI, 2'd1, 5'd4, SEL_NONE, SEL_NONE);
                        3'd7: d = mk(OP_EI, 2'd1, 5'd4, SEL_NONE, SEL_NONE);
                        default: ;
                    endcase
                3'd4:
                    case (y)
                        3'd0: d = mk(OP_CALLNZ, 2'd3, 5'd12, SEL_IMM16, SEL_NONE);
                        3'd1: d = mk(OP_CALLZ, 2'd3, 5'd12, SEL_IMM16, SEL_NONE);
                        3'd2: d = mk(OP_CALLNC, 2'd3, 5'd12, SEL_IMM16, SEL_NONE);
                        3'd3: d = mk(OP_CALLC, 2'd3, 5'd12, SEL_IMM16, SEL_NONE);
                        default: ;
                    endcase
                3'd5:
                    if (!q)
                        d = mk(OP_PUSH16, 2'd1, 5'd16,
                               (p == 2'd3) ? SEL_AF : SEL_BC + {3'd0, p}, SEL_NONE);
                    else if (p == 2'd0)
                        d = mk(OP_CALL, 2'd3, 5'd24, SEL_IMM16, SEL_NONE);
                3'd6:
                    d = mk(OP_ADD8 + {4'd0, y}, 2'd2, 5'd8, SEL_A, SEL_IMM8);
                default:
                begin
                    d = mk(OP_RST, 2'd1, 5'd16, SEL_NONE, SEL_NONE);
                    d.bit_or_vector = {y, 3'd0};
                end
            endcase
        end
    end

    assign dec = d;

endmodule
